// ===== hdl/assert_macros.svh =====
// Assertion macros for the bank mapper RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CMBM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
`define CMBM_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define CMBM_ASSERT(lbl, clk, rst_n, prop)
`define CMBM_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== hdl/cmbm_pkg.sv =====
// Package for the console memory map bank mapper.
// Item types, request, target and I/O port codes, memory sizes and register indexes; no dependencies.
`timescale 1ns / 1ps

package cmbm_pkg;

  localparam int unsigned BaseRamBytes = 1024;
  localparam int unsigned ExpRamBytes  = 32768;
  localparam int unsigned PageBytes    = 8192;

  localparam int unsigned BaseAw = $clog2(BaseRamBytes);
  localparam int unsigned ExpAw  = $clog2(ExpRamBytes);
  localparam int unsigned PageSh = $clog2(PageBytes);

  localparam logic [1:0] REQ_MEM_RD = 2'd0;
  localparam logic [1:0] REQ_MEM_WR = 2'd1;
  localparam logic [1:0] REQ_IO_WR  = 2'd2;

  localparam logic [1:0] TGT_DATA = 2'd0;
  localparam logic [1:0] TGT_BIOS = 2'd1;
  localparam logic [1:0] TGT_CART = 2'd2;
  localparam logic [1:0] TGT_NONE = 2'd3;

  localparam logic REG_MEGA_CART_MODE  = 1'b0;
  localparam logic REG_CART_SIZE_BYTES = 1'b1;

  localparam logic [7:0] PORT_UPPER_EN = 8'h53;
  localparam logic [7:0] PORT_LOWER_EN = 8'h7f;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [7:0]  read_data;
    logic [19:0] rom_address;
  } out_item_t;

endpackage

// ===== hdl/console_memory_map_bank_mapper.sv =====
// Top level of the console memory map bank mapper.
// Depends on cmbm_pkg and assert_macros.svh.
//
// Usage: each input item is one CPU bus access (memory read, memory write or
// I/O port write) on the in channel; each accepted item yields exactly one
// result item on the out channel, in order. An item is taken on a rising edge
// with valid high and stall low.
// Pipeline: an accepted item passes the RAM read stage, which reads the base
// or expansion RAM (synchronous read), and then the output register, which
// registers the result. Throughput is one item per cycle while in_stall_o is
// low, set by the single access per item to each RAM port.
// Reset: control state clears at once, then the expansion RAM is swept to
// 0xFF, one byte per cycle, all 32768 bytes, with in_stall_o held high. The
// APB port takes register writes during the sweep. Base RAM is not cleared.
// Stall: when out_stall_i holds a result, one more item is still taken into
// the RAM read stage; after that in_stall_o rises until the result leaves.
// Registers: 0x0 mega_cart_mode, 0x4 cart_size_bytes; pready is always high.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module console_memory_map_bank_mapper (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cmbm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cmbm_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [1:0] {
    SRC_EXP,
    SRC_BASE,
    SRC_FF,
    SRC_ZERO
  } src_e;

  logic        mega_q;
  logic [20:0] cart_size_q;
  logic        lower_on_q, upper_on_q;
  logic [19:0] bank_base_q, bank_base_d;
  logic        lower_on_d, upper_on_d;

  logic [7:0] exp_mem  [cmbm_pkg::ExpRamBytes];
  logic [7:0] base_mem [cmbm_pkg::BaseRamBytes];
  logic [7:0] exp_rd_q, base_rd_q;

  logic                     clr_busy_q;
  logic [cmbm_pkg::ExpAw-1:0] clr_cnt_q;

  logic        s1_valid_q;
  src_e        s1_src_q;
  logic [1:0]  s1_tgt_q;
  logic [19:0] s1_rom_q;
  logic        out_valid_q;
  cmbm_pkg::out_item_t out_q;

  logic        cfg_we;
  logic        in_accept, s1_move;
  src_e        dec_src;
  logic [1:0]  dec_tgt;
  logic [19:0] dec_rom;
  logic        exp_we, base_we;

  logic [15:0] addr;
  logic [7:0]  wbyte;
  logic [8:0]  pages;
  logic [7:0]  banks, bank_mask;
  logic        bank_sel, beyond;
  logic [19:0] bank_new, bank_eff, fixed_rom;
  logic [21:0] cart_end;
  logic                       exp_wr_en;
  logic [cmbm_pkg::ExpAw-1:0] exp_wr_addr;
  logic [7:0]                 exp_wr_data;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[2])
      cmbm_pkg::REG_MEGA_CART_MODE:  prdata = {31'd0, mega_q};
      cmbm_pkg::REG_CART_SIZE_BYTES: prdata = {11'd0, cart_size_q};
      default:                       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mega_q      <= 1'b0;
      cart_size_q <= '0;
    end else if (cfg_we) begin
      unique case (paddr[2])
        cmbm_pkg::REG_MEGA_CART_MODE:  mega_q      <= pwdata[0];
        cmbm_pkg::REG_CART_SIZE_BYTES: cart_size_q <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_move    = s1_valid_q & ~(out_valid_q & out_stall_i);
  assign in_stall_o = clr_busy_q | (s1_valid_q & out_valid_q & out_stall_i);
  assign in_accept  = in_valid_i & ~in_stall_o;

  // decode
  assign addr  = in_item_i.address;
  assign wbyte = in_item_i.write_byte;

  assign pages     = 9'(({1'b0, cart_size_q} + 22'(cmbm_pkg::PageBytes - 1))
                        >> cmbm_pkg::PageSh);
  assign banks     = pages[8:1];
  assign bank_mask = (banks == 8'd0) ? 8'd0 : banks - 8'd1;
  assign bank_new  = {addr[5:0] & bank_mask[5:0], 14'd0};
  assign bank_sel  = mega_q & (addr >= 16'hffc0);
  assign bank_eff  = bank_sel ? bank_new : bank_base_q;
  assign cart_end  = {1'b0, cart_size_q} + 22'h8000;
  assign beyond    = {6'd0, addr} >= cart_end;
  assign fixed_rom = cart_size_q[19:0] - 20'h4000 + {6'd0, addr[13:0]};

  always_comb begin
    dec_src     = SRC_ZERO;
    dec_tgt     = cmbm_pkg::TGT_NONE;
    dec_rom     = '0;
    exp_we      = 1'b0;
    base_we     = 1'b0;
    lower_on_d  = lower_on_q;
    upper_on_d  = upper_on_q;
    bank_base_d = bank_base_q;
    unique case (in_item_i.req_type)
      cmbm_pkg::REQ_MEM_RD: begin
        dec_tgt = cmbm_pkg::TGT_DATA;
        priority if (addr < 16'h2000) begin
          if (lower_on_q) begin
            dec_src = SRC_EXP;
          end else begin
            dec_tgt = cmbm_pkg::TGT_BIOS;
            dec_rom = {4'd0, addr};
          end
        end else if (addr < 16'h8000 && upper_on_q) begin
          dec_src = SRC_EXP;
        end else if (addr < 16'h6000) begin
          dec_src = SRC_FF;
        end else if (addr < 16'h8000) begin
          dec_src = SRC_BASE;
        end else begin
          if (bank_sel) begin
            bank_base_d = bank_new;
          end
          if (beyond) begin
            dec_src = SRC_FF;
          end else begin
            dec_tgt = cmbm_pkg::TGT_CART;
            priority if (!mega_q) begin
              dec_rom = {5'd0, addr[14:0]};
            end else if (!addr[14]) begin
              dec_rom = fixed_rom;
            end else begin
              dec_rom = {bank_eff[19:14], addr[13:0]};
            end
          end
        end
      end
      cmbm_pkg::REQ_MEM_WR: begin
        priority if (addr < 16'h2000) begin
          exp_we = lower_on_q;
        end else if (addr < 16'h8000) begin
          exp_we  = upper_on_q;
          base_we = ~upper_on_q & (addr >= 16'h6000);
        end else begin
          exp_we = 1'b0;
        end
      end
      cmbm_pkg::REQ_IO_WR: begin
        priority if (addr[7:0] == cmbm_pkg::PORT_UPPER_EN) begin
          upper_on_d = 1'b1;
        end else if (addr[7:0] == cmbm_pkg::PORT_LOWER_EN) begin
          lower_on_d = ~wbyte[1];
        end else begin
          upper_on_d = upper_on_q;
        end
      end
      default: ;
    endcase
  end

  // mapper state and clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_on_q  <= 1'b0;
      upper_on_q  <= 1'b0;
      bank_base_q <= '0;
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
    end else begin
      if (in_accept) begin
        lower_on_q  <= lower_on_d;
        upper_on_q  <= upper_on_d;
        bank_base_q <= bank_base_d;
      end
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  // memories
  assign exp_wr_en   = clr_busy_q | (in_accept & exp_we);
  assign exp_wr_addr = clr_busy_q ? clr_cnt_q : addr[cmbm_pkg::ExpAw-1:0];
  assign exp_wr_data = clr_busy_q ? 8'hff : wbyte;

  always_ff @(posedge clk_i) begin
    if (exp_wr_en) begin
      exp_mem[exp_wr_addr] <= exp_wr_data;
    end
    if (in_accept) begin
      exp_rd_q <= exp_mem[addr[cmbm_pkg::ExpAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && base_we) begin
      base_mem[addr[cmbm_pkg::BaseAw-1:0]] <= wbyte;
    end
    if (in_accept) begin
      base_rd_q <= base_mem[addr[cmbm_pkg::BaseAw-1:0]];
    end
  end

  // read stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_src_q <= dec_src;
      s1_tgt_q <= dec_tgt;
      s1_rom_q <= dec_rom;
    end
    if (s1_move) begin
      out_q.target      <= s1_tgt_q;
      out_q.rom_address <= s1_rom_q;
      unique case (s1_src_q)
        SRC_EXP:  out_q.read_data <= exp_rd_q;
        SRC_BASE: out_q.read_data <= base_rd_q;
        SRC_FF:   out_q.read_data <= 8'hff;
        SRC_ZERO: out_q.read_data <= 8'h00;
        default:  out_q.read_data <= 8'h00;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `CMBM_ASSERT_NR(a_reset_no_out, clk_i, !rst_ni |-> !out_valid_o)
  `CMBM_ASSERT(a_clear_no_out, clk_i, rst_ni, clr_busy_q |-> !out_valid_q && !s1_valid_q)
  `CMBM_ASSERT(a_clear_full_sweep, clk_i, rst_ni,
               $fell(clr_busy_q) |-> $past(clr_cnt_q) == '1)
  `CMBM_ASSERT(a_s1_kept, clk_i, rst_ni, s1_valid_q && !s1_move |=> s1_valid_q)
  `CMBM_ASSERT(a_rom_zero, clk_i, rst_ni,
               out_valid_q && out_q.target != cmbm_pkg::TGT_BIOS &&
               out_q.target != cmbm_pkg::TGT_CART |-> out_q.rom_address == '0)
  `CMBM_ASSERT(a_none_no_data, clk_i, rst_ni,
               out_valid_q && out_q.target == cmbm_pkg::TGT_NONE |-> out_q.read_data == '0)

endmodule
